FILE: rtl/core/gga_pkg.sv
// ---------------------------------------------------------------------------
// gga_pkg: shared types and constants for the GGA field extractor
// Character codes, fixed-point widths, number phase codes and helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package gga_pkg;

    // fixed-point format of a converted field
    localparam int FRAC_DIGITS = 5;
    localparam int INT_DIGITS  = 7;
    localparam int MAG_W       = 40;
    localparam int VALUE_W     = MAG_W + 1;
    localparam int SUM_W       = MAG_W + 4;

    // largest magnitude, 10^(INT_DIGITS+FRAC_DIGITS)-1
    localparam logic [MAG_W-1:0] SAT_LIMIT = 40'd999999999999;
    // weight of one integer digit, 10^FRAC_DIGITS
    localparam logic [16:0]      INT_SCALE = 17'd100000;

    typedef logic [MAG_W-1:0]          t_mag;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [7:0]                t_char;

    // number conversion phases
    localparam logic [2:0] PH_WS   = 3'd0;
    localparam logic [2:0] PH_SIGN = 3'd1;
    localparam logic [2:0] PH_INT  = 3'd2;
    localparam logic [2:0] PH_FRAC = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;

    // which held value
    localparam logic [1:0] IDX_LAT = 2'd0;
    localparam logic [1:0] IDX_LON = 2'd1;
    localparam logic [1:0] IDX_ALT = 2'd2;

    // character codes
    localparam t_char CH_NUL   = 8'h00;
    localparam t_char CH_COMMA = 8'h2C;
    localparam t_char CH_PLUS  = 8'h2B;
    localparam t_char CH_MINUS = 8'h2D;
    localparam t_char CH_POINT = 8'h2E;
    localparam t_char CH_SPACE = 8'h20;
    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_CR    = 8'h0D;
    localparam t_char CH_ZERO  = 8'h30;
    localparam t_char CH_NINE  = 8'h39;
    localparam t_char CH_N     = 8'h4E;
    localparam t_char CH_S     = 8'h53;
    localparam t_char CH_E     = 8'h45;
    localparam t_char CH_W     = 8'h57;
    localparam t_char CH_M     = 8'h4D;

    // weight of a fraction digit by its position after the point
    function automatic logic [13:0] frac_weight(input logic [2:0] pos);
        logic [13:0] w;
        unique case (pos)
            3'd0:    w = 14'd10000;
            3'd1:    w = 14'd1000;
            3'd2:    w = 14'd100;
            3'd3:    w = 14'd10;
            3'd4:    w = 14'd1;
            default: w = 14'd0;
        endcase
        return w;
    endfunction

    // single-character field that closes one of the three quantities
    function automatic logic is_marker(input logic [1:0] which, input t_char c);
        logic hit;
        unique case (which)
            IDX_LAT: hit = (c == CH_N) || (c == CH_S);
            IDX_LON: hit = (c == CH_E) || (c == CH_W);
            IDX_ALT: hit = (c == CH_M);
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gga_field_extractor.sv
// ---------------------------------------------------------------------------
// gga_field_extractor: latitude, longitude and altitude from a GGA sentence
// Streams sentence characters, converts comma fields to fixed point and
// reports the three values on the character marked last.
// ---------------------------------------------------------------------------
// The block takes one character per clock cycle while o_in_ready is high; the
// field accumulator (multiply by ten, add the digit weight, saturate) updates
// in the same cycle the character is accepted. A result sits in an output
// register from the cycle after the request that carries the last character is
// accepted. Input is held off only while that result register is full and not
// being taken. Values are signed, in units of 1e-5, saturated to twelve digits.
`default_nettype none

module gga_field_extractor #(
    parameter int MAX_LEN = 128
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_char_in,
    input  wire         i_last_char,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic signed [40:0] o_latitude_value,
    output logic signed [40:0] o_longitude_value,
    output logic signed [40:0] o_altitude_value
);

    localparam int POS_W = $clog2(MAX_LEN + 1);

    // token state
    gga_pkg::t_mag    r_token_mag,   n_token_mag;
    logic             r_token_neg,   n_token_neg;
    logic [2:0]       r_phase,       n_phase;
    logic [2:0]       r_frac_cnt,    n_frac_cnt;
    logic [1:0]       r_token_len,   n_token_len;
    gga_pkg::t_char   r_first_char,  n_first_char;
    // sentence state
    gga_pkg::t_value  r_held  [3];
    gga_pkg::t_value  n_held  [3];
    logic [2:0]       r_marker,      n_marker;
    logic [POS_W-1:0] r_char_pos,    n_char_pos;
    logic             r_string_ended, n_string_ended;
    // result register
    logic             r_out_valid;
    gga_pkg::t_value  r_out_lat, r_out_lon, r_out_alt;

    logic in_acc;
    logic out_acc;

    // handshake
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_latitude_value  = r_out_lat;
    assign o_longitude_value = r_out_lon;
    assign o_altitude_value  = r_out_alt;

    // character classes
    logic              active, is_nul, is_comma, is_digit, is_ws, is_sign;
    logic [3:0]        digit;
    logic [2:0]        eff_phase;
    logic              add_en, add_int;
    logic [gga_pkg::SUM_W-1:0] base_sum, digit_term, acc_sum;
    logic              do_commit;
    gga_pkg::t_value   tok_value;

    assign active   = !r_string_ended && (r_char_pos < POS_W'(MAX_LEN));
    assign is_nul   = (i_char_in == gga_pkg::CH_NUL);
    assign is_comma = (i_char_in == gga_pkg::CH_COMMA);
    assign is_digit = (i_char_in >= gga_pkg::CH_ZERO) && (i_char_in <= gga_pkg::CH_NINE);
    assign is_ws    = (i_char_in == gga_pkg::CH_SPACE)
                   || ((i_char_in >= gga_pkg::CH_TAB) && (i_char_in <= gga_pkg::CH_CR));
    assign is_sign  = (i_char_in == gga_pkg::CH_PLUS) || (i_char_in == gga_pkg::CH_MINUS);
    assign digit    = i_char_in[3:0];

    // whitespace phase falls through to the sign phase on anything else
    assign eff_phase = ((r_phase == gga_pkg::PH_WS) && !is_ws && !is_sign)
                     ? gga_pkg::PH_SIGN : r_phase;

    // digit accumulate: integer digits shift by ten, fraction digits add a weight
    assign add_int  = (eff_phase == gga_pkg::PH_SIGN) || (eff_phase == gga_pkg::PH_INT);
    assign add_en   = is_digit && (add_int || ((eff_phase == gga_pkg::PH_FRAC)
                                 && (r_frac_cnt < 3'(gga_pkg::FRAC_DIGITS))));
    assign base_sum = add_int
                    ? ({1'b0, r_token_mag, 3'b000} + {3'b000, r_token_mag, 1'b0})
                    : {4'b0000, r_token_mag};
    assign digit_term = add_int
                    ? (gga_pkg::SUM_W'(digit) * gga_pkg::SUM_W'(gga_pkg::INT_SCALE))
                    : (gga_pkg::SUM_W'(digit)
                       * gga_pkg::SUM_W'(gga_pkg::frac_weight(r_frac_cnt)));
    assign acc_sum  = base_sum + digit_term;

    // next state of the token and sentence
    always_comb begin
        n_token_mag    = r_token_mag;
        n_token_neg    = r_token_neg;
        n_phase        = r_phase;
        n_frac_cnt     = r_frac_cnt;
        n_token_len    = r_token_len;
        n_first_char   = r_first_char;
        n_held         = r_held;
        n_marker       = r_marker;
        n_char_pos     = r_char_pos;
        n_string_ended = r_string_ended;
        do_commit      = 1'b0;
        tok_value      = '0;

        if (active) begin
            n_char_pos = r_char_pos + 1'b1;
            if (is_nul) begin
                do_commit      = 1'b1;
                n_string_ended = 1'b1;
            end else if (is_comma) begin
                do_commit = 1'b1;
            end else begin
                if (r_token_len == 2'd0) begin
                    n_first_char = i_char_in;
                end
                if (r_token_len != 2'd3) begin
                    n_token_len = r_token_len + 1'b1;
                end
                unique case (eff_phase)
                    gga_pkg::PH_WS: begin
                        if (is_sign) begin
                            n_token_neg = (i_char_in == gga_pkg::CH_MINUS);
                            n_phase     = gga_pkg::PH_SIGN;
                        end
                    end
                    gga_pkg::PH_SIGN, gga_pkg::PH_INT: begin
                        if (is_digit) begin
                            n_phase = gga_pkg::PH_INT;
                        end else if (i_char_in == gga_pkg::CH_POINT) begin
                            n_phase = gga_pkg::PH_FRAC;
                        end else begin
                            n_phase = gga_pkg::PH_DONE;
                        end
                    end
                    gga_pkg::PH_FRAC: begin
                        if (is_digit) begin
                            if (r_frac_cnt < 3'(gga_pkg::FRAC_DIGITS)) begin
                                n_frac_cnt = r_frac_cnt + 1'b1;
                            end
                        end else begin
                            n_phase = gga_pkg::PH_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
                if (add_en) begin
                    n_token_mag = (acc_sum > {4'b0000, gga_pkg::SAT_LIMIT})
                                ? gga_pkg::SAT_LIMIT : acc_sum[gga_pkg::MAG_W-1:0];
                end
            end
        end

        // the last character closes a pending field unless NUL already did
        if (i_last_char && !n_string_ended) begin
            do_commit = 1'b1;
        end

        // commit the field into the quantities not yet closed by a marker
        if (do_commit && (n_token_len != 2'd0)) begin
            tok_value = n_token_neg ? -$signed({1'b0, n_token_mag})
                                    :  $signed({1'b0, n_token_mag});
            for (int i = 0; i < 3; i++) begin
                if (!r_marker[i]) begin
                    if ((n_token_len == 2'd1) && gga_pkg::is_marker(2'(i), n_first_char)) begin
                        n_marker[i] = 1'b1;
                    end else begin
                        n_held[i] = tok_value;
                    end
                end
            end
        end
        if (do_commit) begin
            n_token_mag  = '0;
            n_token_neg  = 1'b0;
            n_phase      = gga_pkg::PH_WS;
            n_frac_cnt   = '0;
            n_token_len  = '0;
            n_first_char = '0;
        end
    end

    // state registers, cleared after each sentence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_last_char)) begin
            r_token_mag    <= '0;
            r_token_neg    <= 1'b0;
            r_phase        <= gga_pkg::PH_WS;
            r_frac_cnt     <= '0;
            r_token_len    <= '0;
            r_first_char   <= '0;
            r_held[0]      <= '0;
            r_held[1]      <= '0;
            r_held[2]      <= '0;
            r_marker       <= '0;
            r_char_pos     <= '0;
            r_string_ended <= 1'b0;
        end else if (in_acc) begin
            r_token_mag    <= n_token_mag;
            r_token_neg    <= n_token_neg;
            r_phase        <= n_phase;
            r_frac_cnt     <= n_frac_cnt;
            r_token_len    <= n_token_len;
            r_first_char   <= n_first_char;
            r_held         <= n_held;
            r_marker       <= n_marker;
            r_char_pos     <= n_char_pos;
            r_string_ended <= n_string_ended;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_last_char) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_char) begin
            r_out_lat <= n_held[gga_pkg::IDX_LAT];
            r_out_lon <= n_held[gga_pkg::IDX_LON];
            r_out_alt <= n_held[gga_pkg::IDX_ALT];
        end
    end

    // checks
    a_mag_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_token_mag <= gga_pkg::SAT_LIMIT)
        else $error("token magnitude above saturation limit");

    a_frac_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac_cnt <= 3'(gga_pkg::FRAC_DIGITS))
        else $error("fraction digit count out of range");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_char_pos <= POS_W'(MAX_LEN))
        else $error("character position beyond sentence limit");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_last_char |=> (r_char_pos == '0) && !r_string_ended
                                  && (r_marker == '0) && r_out_valid)
        else $error("sentence state not cleared after last character");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

`default_nettype wire
